@@ hw/rtl/mstt_pkg.sv @@
// Shared types, codes and helpers for the deadline timer table.
package mstt_pkg;

	localparam logic [1:0] OpSched  = 2'd0;
	localparam logic [1:0] OpCancel = 2'd1;
	localparam logic [1:0] OpTick   = 2'd2;

	localparam logic [1:0] StOk       = 2'd0;
	localparam logic [1:0] StFull     = 2'd1;
	localparam logic [1:0] StNotFound = 2'd2;

	// At most this many timers fire on one tick.
	localparam int FireCntW = 5;
	localparam logic [FireCntW-1:0] MaxFires = FireCntW'(16);

	// Request as it travels along the row of slot cells.
	typedef struct packed {
		logic [1:0]          op;
		logic [47:0]         now;
		logic [31:0]         ivl;
		logic                rep;
		logic [31:0]         cid;
		logic [31:0]         nid;
		logic [47:0]         dl;
		logic                done;
		logic [FireCntW-1:0] nfire;
	} mstt_tok_t;

	// Time plus delay, saturating at the top of the 48-bit range.
	function automatic logic [47:0] sat_add48(input logic [47:0] t, input logic [31:0] d);
		logic [48:0] s;
		s = {1'b0, t} + {17'b0, d};
		return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
	endfunction

endpackage

@@ hw/rtl/mstt_cell.sv @@
// One timer slot: holds its timer and passes the request on to the next slot.
module mstt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_v,
	input  mstt_pkg::mstt_tok_t in_tok,
	output logic              out_v,
	output mstt_pkg::mstt_tok_t out_tok,
	output logic              fire,
	output logic [31:0]       fire_id
);
	import mstt_pkg::*;

	logic        in_use_q;
	logic        periodic_q;
	logic [31:0] period_q;
	logic [47:0] deadline_q;
	logic [31:0] owner_q;
	logic        out_v_q;
	mstt_tok_t   out_tok_q;

	logic        hit_free;
	logic        hit_cancel;
	logic [47:0] rearm_dl;
	mstt_tok_t   nxt_tok;

	assign hit_free   = in_v && (in_tok.op == OpSched) && !in_tok.done && !in_use_q;
	assign hit_cancel = in_v && (in_tok.op == OpCancel) && !in_tok.done && in_use_q
		&& (owner_q == in_tok.cid);
	assign fire       = in_v && (in_tok.op == OpTick) && in_use_q
		&& (deadline_q < in_tok.now) && (in_tok.nfire < MaxFires);
	assign fire_id    = owner_q;
	assign rearm_dl   = sat_add48(in_tok.now, period_q);

	always_comb begin
		nxt_tok = in_tok;
		nxt_tok.done = in_tok.done | hit_free | hit_cancel;
		if (fire) begin
			nxt_tok.nfire = in_tok.nfire + FireCntW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			out_v_q <= in_v;
			if (hit_free) begin
				in_use_q <= 1'b1;
			end else if (hit_cancel) begin
				in_use_q <= 1'b0;
			end else if (fire && !periodic_q) begin
				in_use_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		out_tok_q <= nxt_tok;
		if (hit_free) begin
			periodic_q <= in_tok.rep;
			period_q   <= in_tok.ivl;
			deadline_q <= in_tok.dl;
			owner_q    <= in_tok.nid;
		end else if (fire && periodic_q) begin
			deadline_q <= rearm_dl;
		end
	end

	assign out_v   = out_v_q;
	assign out_tok = out_tok_q;

endmodule

@@ hw/rtl/multi_slot_deadline_timer_table.sv @@
// Top level of the deadline timer table: request entry, slot row and result logic.
//
//  Port group        Direction  Handshake
//  request           in         start high while busy low accepts opcode and operands
//  result            out        result_strobe marks status, timer_id, fired, last for one cycle
//
// A request enters a register, then moves through one slot cell per clock. busy stays high
// from the accepting edge until the request leaves the last slot cell, so a new request is
// taken only after the last one has left the row; its final result is registered as it leaves.
// Expired timers are reported as the request passes their slots, at most one result a cycle,
// each held back by one so that the final one can carry last.
// Reset clears every slot to free and the id counter to zero; nothing else waits on it.
// The receiver cannot stall; results appear whether or not anyone is looking.
module multi_slot_deadline_timer_table #(
	parameter int NUM_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [47:0] now_ms,
	input  logic [31:0] interval_ms,
	input  logic        repeat_flag,
	input  logic [31:0] cancel_id,
	output logic        result_strobe,
	output logic [1:0]  status,
	output logic [31:0] timer_id,
	output logic        fired,
	output logic        last
);
	import mstt_pkg::*;

	logic        busy_q;
	logic [31:0] id_ctr_q;
	logic        pend_v_q;
	logic [31:0] pend_id_q;
	logic        strobe_q;
	logic [1:0]  status_q;
	logic [31:0] id_q;
	logic        fired_q;
	logic        last_q;
	logic        ent_v_q;
	mstt_tok_t   ent_tok_q;

	logic                  accept;
	logic [31:0]           nid;
	mstt_tok_t             ent_tok;
	logic [NUM_TIMERS:0]   tv;
	mstt_tok_t             tk [NUM_TIMERS+1];
	logic [NUM_TIMERS-1:0] fire_v;
	logic [31:0]           fire_ids [NUM_TIMERS];
	logic                  any_fire;
	logic [31:0]           fid;
	logic                  fin_v;
	mstt_tok_t             fin_tok;

	assign accept = start && !busy_q;
	// Ids skip zero when the counter wraps.
	assign nid    = ((id_ctr_q + 32'd1) == 32'd0) ? 32'd1 : id_ctr_q + 32'd1;

	always_comb begin
		ent_tok.op    = opcode;
		ent_tok.now   = now_ms;
		ent_tok.ivl   = interval_ms;
		ent_tok.rep   = repeat_flag;
		ent_tok.cid   = cancel_id;
		ent_tok.nid   = nid;
		ent_tok.dl    = sat_add48(now_ms, interval_ms);
		ent_tok.done  = 1'b0;
		ent_tok.nfire = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_v_q <= 1'b0;
		end else begin
			ent_v_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_tok_q <= ent_tok;
		end
	end

	assign tv[0] = ent_v_q;
	assign tk[0] = ent_tok_q;

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_slot
		mstt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_v    (tv[i]),
			.in_tok  (tk[i]),
			.out_v   (tv[i+1]),
			.out_tok (tk[i+1]),
			.fire    (fire_v[i]),
			.fire_id (fire_ids[i])
		);
	end

	// Only one request is in the row, so at most one slot fires in a cycle.
	always_comb begin
		fid = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			fid = fid | (fire_ids[i] & {32{fire_v[i]}});
		end
	end

	assign any_fire = |fire_v;
	assign fin_v    = tv[NUM_TIMERS];
	assign fin_tok  = tk[NUM_TIMERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			id_ctr_q <= '0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (fin_v) begin
				busy_q <= 1'b0;
				unique case (fin_tok.op)
					OpSched: begin
						strobe_q <= 1'b1;
						if (fin_tok.done) begin
							id_ctr_q <= fin_tok.nid;
						end
					end
					OpCancel: begin
						strobe_q <= 1'b1;
					end
					OpTick: begin
						strobe_q <= pend_v_q;
						pend_v_q <= 1'b0;
					end
					default: begin
						strobe_q <= 1'b0;
					end
				endcase
			end else begin
				if (accept) begin
					busy_q <= 1'b1;
				end
				if (any_fire) begin
					strobe_q <= pend_v_q;
					pend_v_q <= 1'b1;
				end else begin
					strobe_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_v) begin
			last_q <= 1'b1;
			unique case (fin_tok.op)
				OpSched: begin
					status_q <= fin_tok.done ? StOk : StFull;
					id_q     <= fin_tok.done ? fin_tok.nid : 32'd0;
					fired_q  <= 1'b0;
				end
				OpCancel: begin
					status_q <= fin_tok.done ? StOk : StNotFound;
					id_q     <= 32'd0;
					fired_q  <= 1'b0;
				end
				OpTick: begin
					status_q <= StOk;
					id_q     <= pend_id_q;
					fired_q  <= 1'b1;
				end
				default: begin
					status_q <= StOk;
					id_q     <= 32'd0;
					fired_q  <= 1'b0;
				end
			endcase
		end else if (any_fire) begin
			status_q  <= StOk;
			id_q      <= pend_id_q;
			fired_q   <= 1'b1;
			last_q    <= 1'b0;
			pend_id_q <= fid;
		end
	end

	assign busy          = busy_q;
	assign result_strobe = strobe_q;
	assign status        = status_q;
	assign timer_id      = id_q;
	assign fired         = fired_q;
	assign last          = last_q;

	a_idle_row_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tv == '0))
		else $error("request present in the slot row while idle");

	a_single_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(fire_v))
		else $error("more than one slot fired in one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("busy not raised after a request was taken");

	a_end_frees: assert property (@(posedge clk) disable iff (!arst_n)
		fin_v |=> !busy_q && !pend_v_q)
		else $error("block still busy or holding a fire after the request ended");

endmodule
